>>> hw/rtl/brace_template_tokenizer_assert.svh
// ------------------------------------------------------------------------
// Brace template tokenizer assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ------------------------------------------------------------------------
`ifndef BRACE_TEMPLATE_TOKENIZER_ASSERT_SVH
`define BRACE_TEMPLATE_TOKENIZER_ASSERT_SVH

// condition holds at every edge
`define BTT_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define BTT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BTT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/btt_pkg.sv
// ------------------------------------------------------------------------
// Brace template tokenizer package
// Token kinds, scan phases, character codes and result types.
// ------------------------------------------------------------------------
`default_nettype none

package btt_pkg;

	localparam logic [2:0] K_END     = 3'd0;
	localparam logic [2:0] K_INVALID = 3'd1;
	localparam logic [2:0] K_DEFINER = 3'd2;
	localparam logic [2:0] K_VALUE   = 3'd3;
	localparam logic [2:0] K_OPEN    = 3'd4;
	localparam logic [2:0] K_CLOSE   = 3'd5;

	localparam logic [2:0] PH_SKIP     = 3'd0;
	localparam logic [2:0] PH_AT       = 3'd1;
	localparam logic [2:0] PH_DEF      = 3'd2;
	localparam logic [2:0] PH_AFTER_AT = 3'd3;
	localparam logic [2:0] PH_VALUE    = 3'd4;

	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_US     = 8'h5F;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_DIG_0  = 8'h30;
	localparam logic [7:0] CH_DIG_9  = 8'h39;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = QAW + 1;

	typedef struct packed {
		logic [2:0]  token_kind;
		logic [15:0] start_offset;
		logic [15:0] token_length;
		logic [15:0] start_line;
		logic        run_last;
	} btt_result_t;

	typedef struct packed {
		logic        v0;
		logic        v1;
		btt_result_t r0;
		btt_result_t r1;
	} btt_push_t;

	function automatic logic is_space(logic [7:0] b);
		return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic logic is_alpha(logic [7:0] b);
		return (b >= CH_LC_A && b <= CH_LC_Z) || (b >= CH_UC_A && b <= CH_UC_Z);
	endfunction

	function automatic logic is_ident(logic [7:0] b);
		return is_alpha(b) || (b >= CH_DIG_0 && b <= CH_DIG_9) || (b == CH_US);
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/btt_if.sv
// ------------------------------------------------------------------------
// Brace template tokenizer channels
// Valid/ready channels for content bytes and for tokens.
// ------------------------------------------------------------------------
`default_nettype none

interface btt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_mark;

	modport source(output valid, output data_byte, output end_mark, input ready);
	modport sink(input valid, input data_byte, input end_mark, output ready);
endinterface

interface btt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  token_kind;
	logic [15:0] start_offset;
	logic [15:0] token_length;
	logic [15:0] start_line;
	logic        run_last;

	modport source(output valid, output token_kind, output start_offset,
		output token_length, output start_line, output run_last, input ready);
	modport sink(input valid, input token_kind, input start_offset,
		input token_length, input start_line, input run_last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/btt_core.sv
// ------------------------------------------------------------------------
// Brace template tokenizer core
// Input register, scan state and token classification; up to two
// results per item are handed to the result queue.
// ------------------------------------------------------------------------
`default_nettype none
`include "brace_template_tokenizer_assert.svh"

module btt_core #(
	parameter int POSITION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	btt_in_if.sink              bytes,
	input  logic                room,
	output btt_pkg::btt_push_t  push
);
	import btt_pkg::*;

	typedef logic [POSITION_BITS-1:0] cnt_t;

	localparam cnt_t ONE = cnt_t'(1);
	localparam cnt_t TWO = cnt_t'(2);

	logic       v_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       fire;

	logic [2:0] phase_q;
	cnt_t       pos_q, line_q, pstart_q, plen_q, pline_q;

	logic [2:0] phase_d;
	cnt_t       pos_d, line_d, pstart_d, plen_d, pline_d;

	logic        d_space, d_emit;
	logic [2:0]  d_phase;
	btt_result_t d_res;

	logic        v0, v1;
	btt_result_t r0, r1;

	function automatic cnt_t sat_inc(cnt_t v);
		return (v == '1) ? v : cnt_t'(v + 1'b1);
	endfunction

	function automatic btt_result_t mk(logic [2:0] kind, cnt_t off, cnt_t len, cnt_t ln);
		btt_result_t r;
		logic [POSITION_BITS+15:0] eo, el, en;
		eo = {16'b0, off};
		el = {16'b0, len};
		en = {16'b0, ln};
		r.token_kind   = kind;
		r.start_offset = eo[15:0];
		r.token_length = el[15:0];
		r.start_line   = en[15:0];
		r.run_last     = 1'b0;
		return r;
	endfunction

	assign bytes.ready = !v_s1 || room;
	assign fire        = v_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data_byte;
			end_s1  <= bytes.end_mark;
		end
	end

	// dispatch of a byte from the skip phase
	always_comb begin
		d_space = is_space(byte_s1);
		d_emit  = !d_space && (byte_s1 == CH_LBRACE || byte_s1 == CH_RBRACE);
		d_res   = mk((byte_s1 == CH_LBRACE) ? K_OPEN : K_CLOSE, pos_q, ONE, line_q);
		if (byte_s1 == CH_AT) begin
			d_phase = PH_AT;
		end else if (d_space || d_emit) begin
			d_phase = PH_SKIP;
		end else begin
			d_phase = PH_VALUE;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		pos_d    = sat_inc(pos_q);
		line_d   = (byte_s1 == CH_NL) ? sat_inc(line_q) : line_q;
		pstart_d = pstart_q;
		plen_d   = plen_q;
		pline_d  = pline_q;
		v0       = 1'b0;
		v1       = 1'b0;
		r0       = mk(K_END, pos_q, '0, line_q);
		r1       = mk(K_END, pos_q, '0, line_q);
		if (end_s1) begin
			phase_d  = PH_SKIP;
			pos_d    = '0;
			line_d   = '0;
			pstart_d = '0;
			plen_d   = '0;
			pline_d  = '0;
			v0       = 1'b1;
			case (phase_q)
				PH_AT, PH_AFTER_AT: begin
					r0 = mk(K_INVALID, pstart_q, ONE, pline_q);
					v1 = 1'b1;
				end
				PH_DEF: begin
					r0 = mk(K_DEFINER, pstart_q, plen_q, pline_q);
					v1 = 1'b1;
				end
				PH_VALUE: begin
					r0 = mk(K_VALUE, pstart_q, plen_q, pline_q);
					v1 = 1'b1;
				end
				default: begin
					r0 = mk(K_END, pos_q, '0, line_q);
				end
			endcase
		end else begin
			case (phase_q)
				PH_AT: begin
					if (is_alpha(byte_s1) || byte_s1 == CH_US) begin
						phase_d = PH_DEF;
						plen_d  = TWO;
					end else begin
						phase_d = PH_AFTER_AT;
					end
				end
				PH_DEF: begin
					if (byte_s1 == CH_NL || byte_s1 == CH_SP || byte_s1 == CH_LBRACE) begin
						v0      = 1'b1;
						r0      = mk(K_DEFINER, pstart_q, plen_q, pline_q);
						v1      = d_emit;
						r1      = d_res;
						phase_d = d_phase;
						if (!d_space) begin
							pstart_d = pos_q;
							pline_d  = line_q;
						end
						if (d_phase != PH_SKIP) begin
							plen_d = ONE;
						end
					end else if (is_ident(byte_s1)) begin
						plen_d = sat_inc(plen_q);
					end else begin
						v0      = 1'b1;
						r0      = mk(K_INVALID, pstart_q, ONE, pline_q);
						phase_d = PH_SKIP;
					end
				end
				PH_AFTER_AT: begin
					if (byte_s1 == CH_LBRACE) begin
						v0      = 1'b1;
						r0      = mk(K_OPEN, pstart_q, ONE, pline_q);
						phase_d = PH_SKIP;
					end else if (byte_s1 == CH_RBRACE) begin
						v0      = 1'b1;
						r0      = mk(K_CLOSE, pstart_q, ONE, pline_q);
						phase_d = PH_SKIP;
					end else begin
						phase_d = PH_VALUE;
						plen_d  = ONE;
					end
				end
				PH_VALUE: begin
					if (byte_s1 == CH_RBRACE) begin
						v0      = 1'b1;
						r0      = mk(K_VALUE, pstart_q, plen_q, pline_q);
						v1      = 1'b1;
						r1      = mk(K_CLOSE, pos_q, ONE, line_q);
						phase_d = PH_SKIP;
					end else begin
						plen_d = sat_inc(plen_q);
					end
				end
				default: begin
					v0      = d_emit;
					r0      = d_res;
					phase_d = d_phase;
					if (!d_space) begin
						pstart_d = pos_q;
						pline_d  = line_q;
					end
					if (d_phase != PH_SKIP) begin
						plen_d = ONE;
					end
				end
			endcase
		end
	end

	always_comb begin
		push.v0          = fire && v0;
		push.v1          = fire && v1;
		push.r0          = r0;
		push.r1          = r1;
		push.r0.run_last = !v1;
		push.r1.run_last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SKIP;
			pos_q    <= '0;
			line_q   <= '0;
			pstart_q <= '0;
			plen_q   <= '0;
			pline_q  <= '0;
		end else if (fire) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			line_q   <= line_d;
			pstart_q <= pstart_d;
			plen_q   <= plen_d;
			pline_q  <= pline_d;
		end
	end

	`BTT_ASSERT_IMP(a_second_needs_first, push.v1, push.v0, "second result without first")
	`BTT_ASSERT_NXT(a_end_clears, fire && end_s1, phase_q == PH_SKIP && pos_q == '0 && line_q == '0, "end item left scan state")
	`BTT_ASSERT_IMP(a_end_is_last, fire && end_s1, push.v0 && ((push.v1 && push.r1.token_kind == K_END) || (!push.v1 && push.r0.token_kind == K_END)), "end item without end token last")

endmodule

`default_nettype wire

>>> hw/rtl/btt_rqueue.sv
// ------------------------------------------------------------------------
// Brace template tokenizer result queue
// Small register queue that takes up to two results per cycle and
// delivers one per handshake on the token channel.
// ------------------------------------------------------------------------
`default_nettype none
`include "brace_template_tokenizer_assert.svh"

module btt_rqueue (
	input  logic               clk,
	input  logic               arst_n,
	input  btt_pkg::btt_push_t push,
	output logic               room,
	btt_out_if.source          tokens
);
	import btt_pkg::*;

	btt_result_t mem_q [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q, wp_nx;
	logic [QCW-1:0] cnt_q, push_n;
	logic           pop;
	btt_result_t    head;

	assign push_n = QCW'(push.v0) + QCW'(push.v1);
	assign wp_nx  = wp_q + QAW'(1);
	assign room   = cnt_q <= QCW'(QDEPTH - 2);
	assign pop    = tokens.valid && tokens.ready;
	assign head   = mem_q[rp_q];

	assign tokens.valid        = cnt_q != '0;
	assign tokens.token_kind   = head.token_kind;
	assign tokens.start_offset = head.start_offset;
	assign tokens.token_length = head.token_length;
	assign tokens.start_line   = head.start_line;
	assign tokens.run_last     = head.run_last;

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wp_nx] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QAW'(push_n);
			rp_q  <= rp_q + QAW'(pop);
			cnt_q <= cnt_q + push_n - QCW'(pop);
		end
	end

	`BTT_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= QCW'(QDEPTH), "queue count above depth")
	`BTT_ASSERT_IMP(a_push_fits, push.v0, cnt_q <= QCW'(QDEPTH - 2), "push without room")
	`BTT_ASSERT_NXT(a_cnt_track, 1'b1, cnt_q == $past(cnt_q + push_n - QCW'(pop)), "queue count drift")

endmodule

`default_nettype wire

>>> hw/rtl/brace_template_tokenizer.sv
// ------------------------------------------------------------------------
// Brace template tokenizer
// Splits a content byte stream into template tokens.
// ------------------------------------------------------------------------
// bytes : one content byte per item, or end_mark = 1 to close the content.
// tokens: one token per item: kind, start offset, length, start line and
//         run_last, set on the last token caused by one byte item.
// An accepted byte is held in the input register, classified against the
// scan state and, once the queue has room, written to a four-entry result
// queue; its tokens are offered in order from the queue head and each is
// taken on a valid/ready handshake.
// Throughput is one byte per cycle while the queue has room; a byte
// yielding two tokens (value closed by a brace, definer ended by a brace,
// flush before end) needs two handshakes; the queue holds the extra token.
// An end item emits any pending token, then end, and returns the scan state
// to its reset values for the next content.
// Reset empties the queue and clears offset, line and pending counters.
// When the token receiver stalls the queue fills; bytes.ready drops once
// fewer than two entries are free and the input register holds its item.
// Counters saturate at 2^POSITION_BITS - 1; reported fields carry the low
// 16 bits.
// ------------------------------------------------------------------------
`default_nettype none

module brace_template_tokenizer #(
	parameter int POSITION_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	btt_in_if.sink    bytes,
	btt_out_if.source tokens
);
	import btt_pkg::*;

	btt_push_t push;
	logic      room;

	btt_core #(
		.POSITION_BITS(POSITION_BITS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.bytes (bytes),
		.room  (room),
		.push  (push)
	);

	btt_rqueue u_rqueue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.room  (room),
		.tokens(tokens)
	);

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// Brace template tokenizer testbench
// Feeds byte items through a directed table and random template
// documents under varying idle and stall patterns, and compares every
// token with a built-in scan model, or with the table entry on typed rows.
// ------------------------------------------------------------------------

module tb;
	import btt_pkg::*;

	localparam int POS_BITS     = 16;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS  = 400;
	localparam int HOLD_CYCLES  = 300;
	localparam logic [15:0] CNT_TOP = 16'hFFFF;

	typedef struct packed {
		logic [7:0]  data;
		logic        endm;
		logic        typed;
		btt_result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	btt_in_if  in_ch();
	btt_out_if tok_ch();

	brace_template_tokenizer #(.POSITION_BITS(POS_BITS)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (in_ch.sink),
		.tokens (tok_ch.source)
	);

	always #5 clk = ~clk;

	// scan model state
	logic [2:0]  scan_ph;
	logic [15:0] pos_cnt;
	logic [15:0] line_cnt;
	logic [15:0] tok_start;
	logic [15:0] tok_len;
	logic [15:0] tok_line;

	btt_result_t fresh_toks[$];
	btt_result_t tokens_due[$];
	stim_row_t   script [0:27];

	int errors;
	int tok_seen;
	int cycle_cnt;
	int items_sent;
	int src_idle;
	int stall_pct;
	int hold_left;

	function automatic logic blank_ch(logic [7:0] b);
		return b inside {CH_SP, [CH_TAB:CH_CR]};
	endfunction

	function automatic logic letter_ch(logic [7:0] b);
		return b inside {[CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z]};
	endfunction

	function automatic logic name_ch(logic [7:0] b);
		return letter_ch(b) || (b inside {[CH_DIG_0:CH_DIG_9]}) || b == CH_US;
	endfunction

	function automatic logic [15:0] bump(logic [15:0] v);
		return (v == CNT_TOP) ? v : v + 16'd1;
	endfunction

	function automatic void add_tok(logic [2:0] kind, logic [15:0] off, logic [15:0] len,
		logic [15:0] line);
		btt_result_t t;
		t.token_kind   = kind;
		t.start_offset = off;
		t.token_length = len;
		t.start_line   = line;
		t.run_last     = 1'b0;
		fresh_toks.push_back(t);
	endfunction

	function automatic void clear_scan();
		scan_ph   = PH_SKIP;
		pos_cnt   = '0;
		line_cnt  = '0;
		tok_start = '0;
		tok_len   = '0;
		tok_line  = '0;
	endfunction

	function automatic void start_token(logic [7:0] b, logic [15:0] here);
		if (!blank_ch(b)) begin
			tok_start = here;
			tok_line  = line_cnt;
			if (b == CH_AT) begin
				scan_ph = PH_AT;
				tok_len = 16'd1;
			end else if (b == CH_LBRACE) begin
				add_tok(K_OPEN, here, 16'd1, line_cnt);
			end else if (b == CH_RBRACE) begin
				add_tok(K_CLOSE, here, 16'd1, line_cnt);
			end else begin
				scan_ph = PH_VALUE;
				tok_len = 16'd1;
			end
		end
	endfunction

	function automatic void tokenize(logic [7:0] b, logic endm);
		logic [15:0] here;
		here = pos_cnt;
		fresh_toks.delete();
		if (endm) begin
			case (scan_ph)
				PH_AT, PH_AFTER_AT: add_tok(K_INVALID, tok_start, 16'd1, tok_line);
				PH_DEF:             add_tok(K_DEFINER, tok_start, tok_len, tok_line);
				PH_VALUE:           add_tok(K_VALUE, tok_start, tok_len, tok_line);
				default: ;
			endcase
			add_tok(K_END, pos_cnt, 16'd0, line_cnt);
			fresh_toks[fresh_toks.size() - 1].run_last = 1'b1;
			clear_scan();
		end else begin
			case (scan_ph)
				PH_AT: begin
					if (letter_ch(b) || b == CH_US) begin
						scan_ph = PH_DEF;
						tok_len = 16'd2;
					end else begin
						scan_ph = PH_AFTER_AT;
					end
				end
				PH_DEF: begin
					if (b == CH_NL || b == CH_SP || b == CH_LBRACE) begin
						add_tok(K_DEFINER, tok_start, tok_len, tok_line);
						scan_ph = PH_SKIP;
						start_token(b, here);
					end else if (name_ch(b)) begin
						tok_len = bump(tok_len);
					end else begin
						add_tok(K_INVALID, tok_start, 16'd1, tok_line);
						scan_ph = PH_SKIP;
					end
				end
				PH_AFTER_AT: begin
					if (b == CH_LBRACE) begin
						add_tok(K_OPEN, tok_start, 16'd1, tok_line);
						scan_ph = PH_SKIP;
					end else if (b == CH_RBRACE) begin
						add_tok(K_CLOSE, tok_start, 16'd1, tok_line);
						scan_ph = PH_SKIP;
					end else begin
						scan_ph = PH_VALUE;
						tok_len = 16'd1;
					end
				end
				PH_VALUE: begin
					if (b == CH_RBRACE) begin
						add_tok(K_VALUE, tok_start, tok_len, tok_line);
						add_tok(K_CLOSE, here, 16'd1, line_cnt);
						scan_ph = PH_SKIP;
					end else begin
						tok_len = bump(tok_len);
					end
				end
				default: begin
					scan_ph = PH_SKIP;
					start_token(b, here);
				end
			endcase
			if (b == CH_NL)
				line_cnt = bump(line_cnt);
			pos_cnt = bump(pos_cnt);
			if (fresh_toks.size() > 0)
				fresh_toks[fresh_toks.size() - 1].run_last = 1'b1;
		end
	endfunction

	function automatic logic [7:0] lead_char();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (!(letter_ch(b) || b == CH_US));
		return b;
	endfunction

	function automatic logic [7:0] tail_char();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (!name_ch(b));
		return b;
	endfunction

	function automatic logic [7:0] non_lead();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (letter_ch(b) || b == CH_US);
		return b;
	endfunction

	function automatic logic [7:0] bad_name_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255));
		while (name_ch(b) || b == CH_SP || b == CH_NL || b == CH_LBRACE);
		return b;
	endfunction

	function automatic logic [7:0] free_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == CH_RBRACE);
		return b;
	endfunction

	function automatic logic [7:0] value_lead();
		logic [7:0] b;
		do b = 8'($urandom_range(255));
		while (blank_ch(b) || b == CH_AT || b == CH_LBRACE || b == CH_RBRACE);
		return b;
	endfunction

	task automatic offer_byte(input logic [7:0] b, input logic e, input logic typed,
		input btt_result_t want);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.end_mark  <= e;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		items_sent++;
		tokenize(b, e);
		if (typed)
			tokens_due.push_back(want);
		else
			foreach (fresh_toks[i])
				tokens_due.push_back(fresh_toks[i]);
	endtask

	task automatic send(input logic [7:0] b, input logic e);
		offer_byte(b, e, 1'b0, '0);
	endtask

	task automatic send_doc();
		int nseg;
		int r;
		int k;
		nseg = $urandom_range(1, 12);
		for (int s = 0; s < nseg; s++) begin
			r = $urandom_range(99);
			if (r < 24) begin
				send(CH_AT, 1'b0);
				send(lead_char(), 1'b0);
				k = $urandom_range(0, 6);
				repeat (k) send(tail_char(), 1'b0);
				case ($urandom_range(2))
					0:       send(CH_SP, 1'b0);
					1:       send(CH_NL, 1'b0);
					default: send(CH_LBRACE, 1'b0);
				endcase
			end else if (r < 46) begin
				send(value_lead(), 1'b0);
				k = $urandom_range(0, 7);
				repeat (k) send(free_byte(), 1'b0);
				send(CH_RBRACE, 1'b0);
			end else if (r < 56) begin
				send(CH_LBRACE, 1'b0);
			end else if (r < 62) begin
				send(CH_RBRACE, 1'b0);
			end else if (r < 72) begin
				k = $urandom_range(1, 3);
				repeat (k) send(($urandom_range(5) == 0) ? CH_SP
					: 8'($urandom_range(CH_TAB, CH_CR)), 1'b0);
			end else if (r < 80) begin
				send(CH_AT, 1'b0);
				send(lead_char(), 1'b0);
				k = $urandom_range(0, 3);
				repeat (k) send(tail_char(), 1'b0);
				send(bad_name_byte(), 1'b0);
			end else if (r < 90) begin
				send(CH_AT, 1'b0);
				send(non_lead(), 1'b0);
			end else begin
				send(8'($urandom_range(255)), 1'b0);
			end
		end
		r = $urandom_range(9);
		if (r == 0) begin
			send(CH_AT, 1'b0);
		end else if (r == 1) begin
			send(CH_AT, 1'b0);
			send(non_lead(), 1'b0);
		end else if (r == 2) begin
			send(CH_AT, 1'b0);
			send(lead_char(), 1'b0);
		end
		send(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic run_phase(input int idle, input int stall, input int hold);
		int goal;
		src_idle  = idle;
		stall_pct = stall;
		hold_left = hold;
		goal      = items_sent + PHASE_ITEMS;
		while (items_sent < goal)
			send_doc();
	endtask

	task automatic note_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= 100)
			$display("token %0d: %s got %0d want %0d", tok_seen, what, got, want);
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				tok_ch.ready <= 1'b0;
			end else begin
				tok_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		btt_result_t w;
		if (arst_n && tok_ch.valid && tok_ch.ready) begin
			if (tokens_due.size() == 0) begin
				note_mismatch("unexpected token, kind", tok_ch.token_kind, 0);
			end else begin
				w = tokens_due.pop_front();
				if (tok_ch.token_kind !== w.token_kind)
					note_mismatch("token_kind", tok_ch.token_kind, w.token_kind);
				if (tok_ch.start_offset !== w.start_offset)
					note_mismatch("start_offset", tok_ch.start_offset, w.start_offset);
				if (tok_ch.token_length !== w.token_length)
					note_mismatch("token_length", tok_ch.token_length, w.token_length);
				if (tok_ch.start_line !== w.start_line)
					note_mismatch("start_line", tok_ch.start_line, w.start_line);
				if (tok_ch.run_last !== w.run_last)
					note_mismatch("run_last", tok_ch.run_last, w.run_last);
			end
			tok_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("brace_template_tokenizer regression: fail");
			$finish;
		end
	end

	initial begin
		errors          = 0;
		tok_seen        = 0;
		cycle_cnt       = 0;
		items_sent      = 0;
		src_idle        = 0;
		stall_pct       = 0;
		hold_left       = 0;
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.data_byte = '0;
		in_ch.end_mark  = 1'b0;
		tok_ch.ready    = 1'b0;
		clear_scan();
		script = '{
			'{8'hFF,     1'b1, 1'b1, '{K_END,     16'd0,  16'd0, 16'd0, 1'b1}},
			'{CH_LBRACE, 1'b0, 1'b1, '{K_OPEN,    16'd0,  16'd1, 16'd0, 1'b1}},
			'{CH_TAB,    1'b0, 1'b0, '0},
			'{CH_AT,     1'b0, 1'b0, '0},
			'{CH_UC_Z,   1'b0, 1'b0, '0},
			'{CH_DIG_9,  1'b0, 1'b0, '0},
			'{CH_SP,     1'b0, 1'b0, '0},
			'{CH_AT,     1'b0, 1'b0, '0},
			'{CH_US,     1'b0, 1'b0, '0},
			'{CH_NL,     1'b0, 1'b0, '0},
			'{CH_AT,     1'b0, 1'b0, '0},
			'{CH_LC_A,   1'b0, 1'b0, '0},
			'{CH_LBRACE, 1'b0, 1'b0, '0},
			'{8'h00,     1'b0, 1'b0, '0},
			'{8'hFF,     1'b0, 1'b0, '0},
			'{CH_RBRACE, 1'b0, 1'b0, '0},
			'{CH_AT,     1'b0, 1'b0, '0},
			'{8'h62,     1'b0, 1'b0, '0},
			'{8'h2E,     1'b0, 1'b1, '{K_INVALID, 16'd15, 16'd1, 16'd1, 1'b1}},
			'{CH_AT,     1'b0, 1'b0, '0},
			'{8'h23,     1'b0, 1'b0, '0},
			'{CH_RBRACE, 1'b0, 1'b0, '0},
			'{CH_AT,     1'b0, 1'b0, '0},
			'{8'h80,     1'b0, 1'b0, '0},
			'{CH_CR,     1'b0, 1'b0, '0},
			'{8'h00,     1'b1, 1'b0, '0},
			'{CH_AT,     1'b0, 1'b0, '0},
			'{8'h7F,     1'b1, 1'b0, '0}
		};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			offer_byte(script[i].data, script[i].endm, script[i].typed, script[i].want);

		run_phase(0, 0, HOLD_CYCLES);
		run_phase(75, 0, 0);
		run_phase(0, 75, 0);
		run_phase(35, 35, 0);
		run_phase(0, 0, 0);

		src_idle  = 0;
		stall_pct = 0;
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("brace_template_tokenizer regression: pass");
		else
			$display("brace_template_tokenizer regression: fail");
		$finish;
	end

endmodule
